>>> sv/vertex_dedup_hash_indexer_macros.svh
`ifndef VERTEX_DEDUP_HASH_INDEXER_MACROS_SVH
`define VERTEX_DEDUP_HASH_INDEXER_MACROS_SVH

// same-cycle implication
`define VDHI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VDHI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/vdhi_pkg.sv
`default_nettype none
package vdhi_pkg;

  localparam logic [31:0] HASH_SEED  = 32'd5381;
  localparam int          HASH_SHIFT = 5;
  localparam int          WORDS      = 9;

  localparam logic [1:0] CFG_IGNORE_POSITION = 2'd0;
  localparam logic [1:0] CFG_IGNORE_TEXCOORD = 2'd1;
  localparam logic [1:0] CFG_IGNORE_NORMAL   = 2'd2;

  typedef struct packed {
    logic        first_of_mesh;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] tex_w;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } vertex_t;

  typedef struct packed {
    logic [11:0] vertex_index;
    logic        is_new;
    logic        store_full;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_REM, ST_HEAD, ST_CHK, ST_CMP, ST_MISS, ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load_in;
    logic hash_step;
    logic rem_step;
    logic head_read;
    logic chk;
    logic drop_head;
    logic follow;
    logic set_hit;
    logic insert;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic rem_last;
    logic head_zero;
    logic entry_valid;
    logic entry_match;
    logic link_zero;
    logic out_free;
  } status_t;

  function automatic logic [31:0] mix_word(input logic [31:0] h_in, input logic [31:0] w);
    logic [31:0] h;
    logic [7:0]  b;
    h = h_in;
    for (int i = 0; i < 4; i++) begin
      b = w[8*i +: 8];
      h = ((h << HASH_SHIFT) + h) ^ {{24{b[7]}}, b};
    end
    return h;
  endfunction

  function automatic logic float_eq(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (a_nan || b_nan) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
    return a == b;
  endfunction

endpackage
`default_nettype wire

>>> sv/vertex_dedup_hash_indexer.sv
// Each request runs hash, remainder, head read, chain walk and, on a miss, insert before the
// result is loaded; the walk grows with each further chain entry, the remainder takes extra
// steps when TABLE_BUCKETS is not a power of two, and a stalled result adds its stall.
// Requests: one at a time, none taken until the last result is loaded for output, paced by the
// word-per-cycle hash and the single read port of the vertex store walking the chain.
// Reset: bucket table cleared while no request is taken; config any time.
`default_nettype none
`include "vertex_dedup_hash_indexer_macros.svh"
module vertex_dedup_hash_indexer #(
  parameter int MAX_VERTICES  = 4096,
  parameter int TABLE_BUCKETS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              vertex_valid,
  output logic                   vertex_ready,
  input  wire vdhi_pkg::vertex_t vertex,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output vdhi_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic              cfg_data
);

  vdhi_pkg::cmd_t    cmd;
  vdhi_pkg::status_t st;

  assign cfg_ready = 1'b1;

  vdhi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .st           (st),
    .cmd          (cmd),
    .vertex_ready (vertex_ready)
  );

  vdhi_datapath #(
    .MAX_VERTICES  (MAX_VERTICES),
    .TABLE_BUCKETS (TABLE_BUCKETS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .vertex       (vertex),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  `VDHI_ASSERT_NEXT(a_busy_after_req, clk, rst, vertex_valid && vertex_ready,
                    !vertex_ready, "ready while busy")
  `VDHI_ASSERT_NOW(a_new_not_full, clk, rst, result_valid,
                   !(result.is_new && result.store_full), "new and full")
  `VDHI_ASSERT_NOW(a_full_index_zero, clk, rst, result_valid && result.store_full,
                   result.vertex_index == 12'd0, "full index")

endmodule
`default_nettype wire

>>> sv/vdhi_ctrl.sv
`default_nettype none
module vdhi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              vertex_valid,
  input  wire vdhi_pkg::status_t st,
  output vdhi_pkg::cmd_t         cmd,
  output logic                   vertex_ready
);

  vdhi_pkg::state_t state;
  vdhi_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vdhi_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vdhi_pkg::ST_CLEAR: if (st.clear_last) state_next = vdhi_pkg::ST_IDLE;
      vdhi_pkg::ST_IDLE:  if (vertex_valid) state_next = vdhi_pkg::ST_HASH;
      vdhi_pkg::ST_HASH:  if (st.hash_last) state_next = vdhi_pkg::ST_REM;
      vdhi_pkg::ST_REM:   if (st.rem_last) state_next = vdhi_pkg::ST_HEAD;
      vdhi_pkg::ST_HEAD:  state_next = vdhi_pkg::ST_CHK;
      vdhi_pkg::ST_CHK:   state_next = st.head_zero ? vdhi_pkg::ST_MISS : vdhi_pkg::ST_CMP;
      vdhi_pkg::ST_CMP: begin
        if (!st.entry_valid) state_next = vdhi_pkg::ST_MISS;
        else if (st.entry_match) state_next = vdhi_pkg::ST_DONE;
        else if (st.link_zero) state_next = vdhi_pkg::ST_MISS;
      end
      vdhi_pkg::ST_MISS:  state_next = vdhi_pkg::ST_DONE;
      vdhi_pkg::ST_DONE:  if (st.out_free) state_next = vdhi_pkg::ST_IDLE;
      default:            state_next = vdhi_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    vertex_ready = 1'b0;
    case (state)
      vdhi_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      vdhi_pkg::ST_IDLE: begin
        vertex_ready = 1'b1;
        cmd.load_in = vertex_valid;
      end
      vdhi_pkg::ST_HASH: cmd.hash_step = 1'b1;
      vdhi_pkg::ST_REM:  cmd.rem_step = 1'b1;
      vdhi_pkg::ST_HEAD: cmd.head_read = 1'b1;
      vdhi_pkg::ST_CHK:  cmd.chk = 1'b1;
      vdhi_pkg::ST_CMP: begin
        if (!st.entry_valid) cmd.drop_head = 1'b1;
        else if (st.entry_match) cmd.set_hit = 1'b1;
        else if (!st.link_zero) cmd.follow = 1'b1;
      end
      vdhi_pkg::ST_MISS: cmd.insert = 1'b1;
      vdhi_pkg::ST_DONE: cmd.out_load = st.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/vdhi_datapath.sv
`default_nettype none
module vdhi_datapath #(
  parameter int MAX_VERTICES  = 4096,
  parameter int TABLE_BUCKETS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vdhi_pkg::cmd_t    cmd,
  output vdhi_pkg::status_t      st,
  input  wire vdhi_pkg::vertex_t vertex,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic              cfg_data,
  output vdhi_pkg::result_t      result,
  output logic                   result_valid,
  input  wire logic              result_ready
);

  localparam int HW = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int BW = $clog2(TABLE_BUCKETS);
  localparam bit IS_POW2 = (TABLE_BUCKETS & (TABLE_BUCKETS - 1)) == 0;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_BUCKETS));

  typedef struct packed {
    logic [BW-1:0]              tag;
    logic [HW-1:0]              link;
    logic [vdhi_pkg::WORDS-1:0][31:0] words;
  } row_t;

  row_t          rows  [MAX_VERTICES];
  logic [HW-1:0] heads [TABLE_BUCKETS];

  logic ign_pos;
  logic ign_tex;
  logic ign_norm;

  vdhi_pkg::vertex_t                 in_q;
  logic [vdhi_pkg::WORDS-1:0][31:0]  vw;
  logic [31:0]   h;
  logic [3:0]    hcnt;
  logic [BW-1:0] rem;
  logic [1:0]    rem_cnt;
  logic [63:0]   prod;
  logic [31:0]   qt;
  logic [31:0]   diff;
  logic [BW-1:0] bucket;
  logic [BW-1:0] clr;
  logic [HW-1:0] head_rd;
  logic [HW-1:0] eff_head;
  logic [HW-1:0] cur;
  logic [HW-1:0] cur_idx;
  logic          first;
  logic [HW-1:0] count;
  logic          full;
  row_t          row_q;
  logic [IW-1:0] rd_addr;
  logic          word_on;
  logic          match;
  vdhi_pkg::result_t pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      ign_pos  <= 1'b0;
      ign_tex  <= 1'b0;
      ign_norm <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        vdhi_pkg::CFG_IGNORE_POSITION: ign_pos  <= cfg_data;
        vdhi_pkg::CFG_IGNORE_TEXCOORD: ign_tex  <= cfg_data;
        vdhi_pkg::CFG_IGNORE_NORMAL:   ign_norm <= cfg_data;
        default: ;
      endcase
    end
  end

  assign vw = {in_q.norm_z, in_q.norm_y, in_q.norm_x, in_q.tex_w, in_q.tex_v,
               in_q.tex_u, in_q.pos_z, in_q.pos_y, in_q.pos_x};

  always_comb begin
    case (hcnt) inside
      [4'd0:4'd2]: word_on = !ign_pos;
      [4'd3:4'd5]: word_on = !ign_tex;
      default:     word_on = !ign_norm;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q    <= vertex;
      h       <= vdhi_pkg::HASH_SEED;
      hcnt    <= 4'd0;
      rem     <= '0;
      rem_cnt <= 2'd0;
    end else if (cmd.hash_step) begin
      if (word_on) h <= vdhi_pkg::mix_word(h, vw[hcnt]);
      hcnt <= hcnt + 4'd1;
    end else if (cmd.rem_step) begin
      case (rem_cnt)
        2'd0: prod <= 64'(h) * 64'(RECIP);
        2'd1: qt <= prod[63:32] * 32'(TABLE_BUCKETS);
        default: begin
          if (diff >= 32'(TABLE_BUCKETS)) rem <= BW'(diff - 32'(TABLE_BUCKETS));
          else rem <= BW'(diff);
        end
      endcase
      rem_cnt <= rem_cnt + 2'd1;
    end
  end

  assign diff   = h - qt;
  assign bucket = IS_POW2 ? h[BW-1:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear_step) begin
      clr <= clr + BW'(1);
    end
  end

  assign full = count >= HW'(MAX_VERTICES);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      heads[clr] <= '0;
    end else if (cmd.insert && !full) begin
      heads[bucket] <= count + HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_read) head_rd <= heads[bucket];
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !full) rows[count[IW-1:0]] <= '{tag: bucket, link: eff_head, words: vw};
  end

  assign rd_addr = cmd.chk ? IW'(head_rd - HW'(1)) : IW'(row_q.link - HW'(1));

  always_ff @(posedge clk) begin
    if (cmd.chk || cmd.follow) row_q <= rows[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      cur      <= head_rd;
      eff_head <= head_rd;
      first    <= 1'b1;
    end else if (cmd.follow) begin
      cur   <= row_q.link;
      first <= 1'b0;
    end else if (cmd.drop_head) begin
      eff_head <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_in && vertex.first_of_mesh) begin
      count <= '0;
    end else if (cmd.insert && !full) begin
      count <= count + HW'(1);
    end
  end

  assign cur_idx = cur - HW'(1);

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < vdhi_pkg::WORDS; k++) begin
      if (((k < 3) && !ign_pos) || ((k >= 3) && (k < 6) && !ign_tex) ||
          ((k >= 6) && !ign_norm)) begin
        if (!vdhi_pkg::float_eq(row_q.words[k], vw[k])) match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_hit) begin
      pend <= '{vertex_index: 12'(cur_idx), is_new: 1'b0, store_full: 1'b0};
    end else if (cmd.insert) begin
      if (full) pend <= '{vertex_index: 12'd0, is_new: 1'b0, store_full: 1'b1};
      else pend <= '{vertex_index: 12'(count), is_new: 1'b1, store_full: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) result <= pend;
  end

  always_comb begin
    st             = '0;
    st.clear_last  = clr == BW'(TABLE_BUCKETS - 1);
    st.hash_last   = hcnt == 4'(vdhi_pkg::WORDS - 1);
    st.rem_last    = IS_POW2 || (rem_cnt == 2'd2);
    st.head_zero   = head_rd == '0;
    st.entry_valid = !first || ((cur_idx < count) && (row_q.tag == bucket));
    st.entry_match = match;
    st.link_zero   = row_q.link == '0;
    st.out_free    = !result_valid || result_ready;
  end

endmodule
`default_nettype wire

>>> bench/vertex_dedup_hash_indexer_test.sv
`default_nettype none
module vertex_dedup_hash_indexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_VERTS = 4096;
  localparam int BUCKETS   = 1024;
  localparam int LIMIT     = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vertex_valid = 1'b0;
  logic vertex_ready;
  vdhi_pkg::vertex_t vertex = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  vdhi_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = vdhi_pkg::CFG_IGNORE_POSITION;
  logic cfg_data = 1'b0;

  vertex_dedup_hash_indexer dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  logic [31:0] stored_words [MAX_VERTS][9];
  int          head_of [BUCKETS];
  int          next_of [MAX_VERTS];
  int          stored_count;
  logic [2:0]  skip_group;

  vdhi_pkg::vertex_t pending_vertices[$];
  vdhi_pkg::result_t expected_results[$];
  int      wait_left = 0;
  int      stall_left = 0;
  int      errors = 0;
  int      cycles = 0;

  function automatic bit same_float(logic [31:0] a, logic [31:0] b);
    bit a_nan;
    bit b_nan;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    if (a_nan || b_nan) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b1;
    return a == b;
  endfunction

  function automatic vdhi_pkg::result_t lookup_vertex(vdhi_pkg::vertex_t v);
    logic [31:0] w[9];
    logic [31:0] h;
    logic [7:0]  b;
    int          link;
    int          bkt;
    bit          ok;
    vdhi_pkg::result_t r;
    w = '{v.pos_x, v.pos_y, v.pos_z, v.tex_u, v.tex_v, v.tex_w, v.norm_x, v.norm_y, v.norm_z};
    if (v.first_of_mesh) begin
      foreach (head_of[i]) head_of[i] = 0;
      stored_count = 0;
    end
    h = 32'd5381;
    for (int k = 0; k < 9; k++) begin
      if (!skip_group[k / 3]) begin
        for (int i = 0; i < 4; i++) begin
          b = w[k][8*i +: 8];
          h = (h * 33) ^ {{24{b[7]}}, b};
        end
      end
    end
    bkt = h % BUCKETS;
    link = head_of[bkt];
    while (link != 0) begin
      ok = 1'b1;
      for (int k = 0; k < 9; k++)
        if (!skip_group[k / 3] && !same_float(stored_words[link-1][k], w[k])) ok = 1'b0;
      if (ok) begin
        r.vertex_index = 12'(link - 1);
        r.is_new = 1'b0;
        r.store_full = 1'b0;
        return r;
      end
      link = next_of[link-1];
    end
    if (stored_count >= MAX_VERTS) begin
      r = '0;
      r.store_full = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) stored_words[stored_count][k] = w[k];
    next_of[stored_count] = head_of[bkt];
    head_of[bkt] = stored_count + 1;
    r.vertex_index = 12'(stored_count);
    r.is_new = 1'b1;
    r.store_full = 1'b0;
    stored_count++;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (vertex_valid && vertex_ready) begin
        expected_results.push_back(lookup_vertex(vertex));
        wait_left <= $urandom_range(0, 8);
        if (pending_vertices.size() > 0 && $urandom_range(0, 8) == 0) begin
          vertex_valid <= 1'b0;
        end else if (pending_vertices.size() > 0 && wait_left == 0) begin
          vertex <= pending_vertices.pop_front();
          vertex_valid <= 1'b1;
        end else begin
          vertex_valid <= 1'b0;
        end
      end else if (!vertex_valid && pending_vertices.size() > 0) begin
        if (wait_left > 0) wait_left <= wait_left - 1;
        else begin
          vertex <= pending_vertices.pop_front();
          vertex_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    vdhi_pkg::result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %p", $time, result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (result.vertex_index !== want.vertex_index)
            $display("%0t vertex_index expected %0d actual %0d", $time,
                     want.vertex_index, result.vertex_index);
          if (result.is_new !== want.is_new)
            $display("%0t is_new expected %0b actual %0b", $time, want.is_new, result.is_new);
          if (result.store_full !== want.store_full)
            $display("%0t store_full expected %0b actual %0b", $time,
                     want.store_full, result.store_full);
          if (result !== want) errors++;
        end
        stall_left <= $urandom_range(0, 8);
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == vdhi_pkg::CFG_IGNORE_POSITION) skip_group[0] = val;
    else if (idx == vdhi_pkg::CFG_IGNORE_TEXCOORD) skip_group[1] = val;
    else skip_group[2] = val;
  endtask

  task automatic drain_block();
    while (pending_vertices.size() > 0 || vertex_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_float(int pool);
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FC0_0001 | ($urandom & 32'h803F_FFFF);
      3: return 32'h7F80_0000;
      4: return 32'(($urandom_range(0, pool)) << 20) | 32'h3F00_0000;
      5: return 32'hFFFF_FFFF;
      default: return 32'(($urandom_range(0, pool)) << 16) | 32'h4000_0000;
    endcase
  endfunction

  function automatic vdhi_pkg::vertex_t make_vertex(bit fresh, int pool);
    vdhi_pkg::vertex_t v;
    v.first_of_mesh = fresh;
    v.pos_x = pick_float(pool);
    v.pos_y = pick_float(pool);
    v.pos_z = pick_float(pool);
    v.tex_u = pick_float(pool);
    v.tex_v = pick_float(pool);
    v.tex_w = pick_float(pool);
    v.norm_x = pick_float(pool);
    v.norm_y = pick_float(pool);
    v.norm_z = pick_float(pool);
    return v;
  endfunction

  task automatic random_mesh(int n, int pool);
    vdhi_pkg::vertex_t v;
    vdhi_pkg::vertex_t seen[$];
    for (int i = 0; i < n; i++) begin
      if (seen.size() > 0 && $urandom_range(0, 2) == 0) begin
        v = seen[$urandom_range(0, seen.size() - 1)];
        if ($urandom_range(0, 3) == 0) v.pos_x ^= 32'h8000_0000;
        if ($urandom_range(0, 3) == 0) v.norm_z = $urandom;
      end else if ($urandom_range(0, 9) == 0) begin
        v = vdhi_pkg::vertex_t'({1'b0, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom, $urandom});
      end else begin
        v = make_vertex(1'b0, pool);
      end
      v.first_of_mesh = (i == 0) ? 1'b1 : ($urandom_range(0, 150) == 0);
      seen.push_back(v);
      pending_vertices.push_back(v);
    end
  endtask

  initial begin
    vdhi_pkg::vertex_t v;
    skip_group = 3'b000;
    stored_count = 0;
    foreach (head_of[i]) head_of[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    v = '0;
    v.first_of_mesh = 1'b1;
    pending_vertices.push_back(v);
    v.first_of_mesh = 1'b0;
    v.pos_x = 32'h8000_0000;
    v.norm_z = 32'h8000_0000;
    pending_vertices.push_back(v);
    v = vdhi_pkg::vertex_t'({1'b0, {9{32'hFFFF_FFFF}}});
    pending_vertices.push_back(v);
    pending_vertices.push_back(v);
    v = vdhi_pkg::vertex_t'({1'b0, {9{32'h7F80_0000}}});
    pending_vertices.push_back(v);
    pending_vertices.push_back(v);
    v = vdhi_pkg::vertex_t'({1'b0, {9{32'h5555_5555}}});
    pending_vertices.push_back(v);
    v = vdhi_pkg::vertex_t'({1'b0, {9{32'hAAAA_AAAA}}});
    pending_vertices.push_back(v);
    pending_vertices.push_back(v);
    v = vdhi_pkg::vertex_t'({1'b1, {9{32'h3F80_0000}}});
    pending_vertices.push_back(v);
    pending_vertices.push_back(v);
    drain_block();

    write_reg(vdhi_pkg::CFG_IGNORE_POSITION, 1'b1);
    write_reg(vdhi_pkg::CFG_IGNORE_TEXCOORD, 1'b1);
    write_reg(vdhi_pkg::CFG_IGNORE_NORMAL, 1'b1);
    for (int i = 0; i < 6; i++) pending_vertices.push_back(make_vertex(i == 3, 20));
    drain_block();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(vdhi_pkg::CFG_IGNORE_POSITION, phase[0]);
      write_reg(vdhi_pkg::CFG_IGNORE_TEXCOORD, phase[1]);
      write_reg(vdhi_pkg::CFG_IGNORE_NORMAL, phase[2]);
      random_mesh(170, (phase % 2) ? 6 : 40);
      drain_block();
    end

    write_reg(vdhi_pkg::CFG_IGNORE_POSITION, 1'b0);
    write_reg(vdhi_pkg::CFG_IGNORE_TEXCOORD, 1'b0);
    write_reg(vdhi_pkg::CFG_IGNORE_NORMAL, 1'b0);
    for (int i = 0; i < 300; i++) begin
      v = vdhi_pkg::vertex_t'({1'b0, 32'(i), {8{32'h0}}});
      v.first_of_mesh = (i == 0);
      pending_vertices.push_back(v);
    end
    random_mesh(1, 3);
    for (int i = 0; i < 40; i++) pending_vertices.push_back(make_vertex(1'b0, 10));
    drain_block();

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

>>> vertex_dedup_hash_indexer.f
+incdir+sv
sv/vdhi_pkg.sv
sv/vdhi_ctrl.sv
sv/vdhi_datapath.sv
sv/vertex_dedup_hash_indexer.sv
bench/vertex_dedup_hash_indexer_test.sv
